### rtl/core/fsts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share scheduler package
// Shared widths, operation/status/slot-state codes, reset values and the
// record types used between the scheduler modules.
// ----------------------------------------------------------------------------
package fsts_pkg;

    localparam int RT_W    = 64;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 9;
    localparam int STAT_W  = 2;
    localparam int SST_W   = 3;
    localparam int CHG_W   = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [OP_W-1:0] OP_SUBMIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_FINISH  = 3'd3;
    localparam logic [OP_W-1:0] OP_BLOCK   = 3'd4;
    localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [SST_W-1:0] SLOT_FREE     = 3'd0;
    localparam logic [SST_W-1:0] SLOT_RUNNABLE = 3'd1;
    localparam logic [SST_W-1:0] SLOT_RUNNING  = 3'd2;
    localparam logic [SST_W-1:0] SLOT_BLOCKED  = 3'd3;
    localparam logic [SST_W-1:0] SLOT_FINISHED = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOCHANGE = 2'd3;

    localparam logic [1:0] REG_RUN_CHARGE  = 2'd0;
    localparam logic [1:0] REG_WAKE_CREDIT = 2'd1;
    localparam logic [1:0] REG_EMPTY_START = 2'd2;

    localparam logic [CHG_W-1:0] RST_RUN_CHARGE  = 16'd1000;
    localparam logic [CHG_W-1:0] RST_WAKE_CREDIT = 16'd1000;
    localparam logic [RT_W-1:0]  RST_EMPTY_START = 64'hFFFF_FFFF_FFFF_FC18;

    typedef struct packed {
        logic [SST_W-1:0] state;
        logic [RT_W-1:0]  runtime;
    } t_slot;

    typedef struct packed {
        logic [CHG_W-1:0] run_charge;
        logic [CHG_W-1:0] wake_credit;
        logic [RT_W-1:0]  empty_start;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_scan_ctl;

    typedef struct packed {
        logic            free_found;
        logic            run_found;
        logic [RT_W-1:0] run_rt;
    } t_scan_res;

endpackage

### rtl/core/fair_share_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share task scheduler
// Slot table in one memory of {state, runtime} records. Submit and acquire
// scan the whole table through the memory read port; release, finish, block
// and unblock on a slot in range do a single read-modify-write of one slot.
// ----------------------------------------------------------------------------
// Submit and acquire: strobe after the S_SCAN, S_DRAIN and S_DECIDE states,
//   one slot read per cycle through the single memory read port.
// Release, finish, block, unblock: strobe after the S_READ and S_MODIFY states.
// Unused operation or slot out of range: strobe in the cycle after acceptance.
// busy is low in the strobe cycle, so the next transfer can start there.
// After reset busy stays high while the table is cleared.
module fair_share_task_scheduler
    import fsts_pkg::*;
#(
    parameter int TASK_SLOTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [IDX_W-1:0]   i_task_index,
    output logic               o_result_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [IDX_W-1:0]   o_task_slot,
    output logic [RT_W-1:0]    o_task_runtime,
    output logic [SST_W-1:0]   o_task_state
);

    localparam int AW = $clog2(TASK_SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TASK_SLOTS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_MODIFY = 3'd6;

    t_cfg      w_cfg;
    t_scan_ctl w_scan_ctl;
    t_scan_res w_scan_res;
    logic [AW-1:0] w_free_idx;
    logic [AW-1:0] w_run_idx;

    logic [2:0]        r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic              r_out_vld, n_out_vld;
    logic [STAT_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [RT_W-1:0]   r_rt, n_rt;
    logic [SST_W-1:0]  r_sst, n_sst;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_slot         w_wdata;
    logic [AW-1:0] w_raddr;
    t_slot         w_rdata;

    logic            w_accept;
    logic            w_in_range;
    logic [31:0]     w_in_idx32;
    logic [31:0]     w_free32;
    logic [31:0]     w_run32;
    logic [31:0]     w_idx32;
    logic [RT_W-1:0] w_charged;
    logic [RT_W-1:0] w_credit;
    logic [RT_W-1:0] w_credited;
    t_slot           w_mod;
    logic            w_mod_we;
    logic [STAT_W-1:0] w_mod_status;

    fsts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fsts_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fsts_scan #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_scan_ctl),
        .i_idx      (r_rd_idx),
        .i_slot     (w_rdata),
        .o_res      (w_scan_res),
        .o_free_idx (w_free_idx),
        .o_run_idx  (w_run_idx)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_in_idx32 = 32'(i_task_index);
    assign w_in_range = (w_in_idx32 < 32'(TASK_SLOTS));
    assign w_free32   = 32'(w_free_idx);
    assign w_run32    = 32'(w_run_idx);
    assign w_idx32    = 32'(r_idx);

    assign w_scan_ctl.clear = w_accept;
    assign w_scan_ctl.valid = r_rd_vld;

    // Read-modify-write of one slot; the read data is valid in S_MODIFY.
    assign w_charged  = w_rdata.runtime + RT_W'(w_cfg.run_charge);
    assign w_credit   = RT_W'(w_cfg.wake_credit);
    assign w_credited = (w_rdata.runtime > w_credit) ? (w_rdata.runtime - w_credit)
                                                     : w_rdata.runtime;

    always_comb begin
        w_mod        = w_rdata;
        w_mod_we     = 1'b0;
        w_mod_status = STAT_DONE;
        case (r_op)
            OP_RELEASE: begin
                if (w_rdata.state == SLOT_FINISHED) begin
                    w_mod.state   = SLOT_FREE;
                    w_mod.runtime = '0;
                    w_mod_we      = 1'b1;
                end else if (w_rdata.state == SLOT_RUNNING) begin
                    w_mod.state   = SLOT_RUNNABLE;
                    w_mod.runtime = w_charged;
                    w_mod_we      = 1'b1;
                end else begin
                    w_mod_status = STAT_NOCHANGE;
                end
            end
            OP_FINISH: begin
                w_mod.state = SLOT_FINISHED;
                w_mod_we    = 1'b1;
            end
            OP_BLOCK: begin
                w_mod.state = SLOT_BLOCKED;
                w_mod_we    = 1'b1;
            end
            OP_UNBLOCK: begin
                if (w_rdata.state == SLOT_BLOCKED) begin
                    w_mod.state   = SLOT_RUNNABLE;
                    w_mod.runtime = w_credited;
                    w_mod_we      = 1'b1;
                end else begin
                    w_mod_status = STAT_NOCHANGE;
                end
            end
            default: begin
                w_mod_status = STAT_NOCHANGE;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_out_vld = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_rt      = r_rt;
        n_sst     = r_sst;
        w_we      = 1'b0;
        w_waddr   = r_cnt;
        w_wdata   = '{state: SLOT_FREE, runtime: '0};
        w_raddr   = r_cnt;
        case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_operation;
                    n_idx = w_in_idx32[AW-1:0];
                    n_cnt = '0;
                    if (i_operation == OP_SUBMIT || i_operation == OP_ACQUIRE) begin
                        n_state = S_SCAN;
                    end else if (i_operation == OP_SPARE_A || i_operation == OP_SPARE_B) begin
                        n_out_vld = 1'b1;
                        n_status  = STAT_NOCHANGE;
                        n_slot    = '0;
                        n_rt      = '0;
                        n_sst     = SLOT_FREE;
                    end else if (!w_in_range) begin
                        n_out_vld = 1'b1;
                        n_status  = STAT_NOCHANGE;
                        n_slot    = i_task_index;
                        n_rt      = '0;
                        n_sst     = SLOT_FREE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST_SLOT) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last record reaches the scanner during this cycle.
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state   = S_IDLE;
                n_out_vld = 1'b1;
                n_status  = STAT_DONE;
                if (r_op == OP_SUBMIT) begin
                    if (!w_scan_res.free_found) begin
                        n_status = STAT_FULL;
                        n_slot   = '0;
                        n_rt     = '0;
                        n_sst    = SLOT_FREE;
                    end else begin
                        w_we          = 1'b1;
                        w_waddr       = w_free_idx;
                        w_wdata.state = SLOT_RUNNABLE;
                        w_wdata.runtime = w_scan_res.run_found ? w_scan_res.run_rt
                                                               : w_cfg.empty_start;
                        n_slot = w_free32[IDX_W-1:0];
                        n_rt   = w_wdata.runtime;
                        n_sst  = SLOT_RUNNABLE;
                    end
                end else begin
                    if (!w_scan_res.run_found) begin
                        n_status = STAT_EMPTY;
                        n_slot   = '0;
                        n_rt     = '0;
                        n_sst    = SLOT_FREE;
                    end else begin
                        w_we            = 1'b1;
                        w_waddr         = w_run_idx;
                        w_wdata.state   = SLOT_RUNNING;
                        w_wdata.runtime = w_scan_res.run_rt;
                        n_slot = w_run32[IDX_W-1:0];
                        n_rt   = w_scan_res.run_rt;
                        n_sst  = SLOT_RUNNING;
                    end
                end
            end
            S_READ: begin
                w_raddr = r_idx;
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                w_we      = w_mod_we;
                w_waddr   = r_idx;
                w_wdata   = w_mod;
                n_state   = S_IDLE;
                n_out_vld = 1'b1;
                n_status  = w_mod_status;
                n_slot    = w_idx32[IDX_W-1:0];
                n_rt      = w_mod.runtime;
                n_sst     = w_mod.state;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_vld  <= (r_state == S_SCAN);
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_rd_idx <= r_cnt;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_rt     <= n_rt;
        r_sst    <= n_sst;
    end

    assign o_result_valid = r_out_vld;
    assign o_status       = r_status;
    assign o_task_slot    = r_slot;
    assign o_task_runtime = r_rt;
    assign o_task_state   = r_sst;

endmodule

### rtl/core/fsts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fsts_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler configuration registers
// APB-style register file holding the run charge, the wake credit and the
// start runtime used when nothing is runnable.
// ----------------------------------------------------------------------------
module fsts_regs
    import fsts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_reg_idx;
    logic       w_wr;

    // Registers sit on 8-byte boundaries.
    assign w_reg_idx = paddr[PADDR_W-1:3];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_charge  <= RST_RUN_CHARGE;
            r_cfg.wake_credit <= RST_WAKE_CREDIT;
            r_cfg.empty_start <= RST_EMPTY_START;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_RUN_CHARGE:  r_cfg.run_charge  <= pwdata[CHG_W-1:0];
                REG_WAKE_CREDIT: r_cfg.wake_credit <= pwdata[CHG_W-1:0];
                REG_EMPTY_START: r_cfg.empty_start <= pwdata[RT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_RUN_CHARGE:  prdata = PDATA_W'(r_cfg.run_charge);
            REG_WAKE_CREDIT: prdata = PDATA_W'(r_cfg.wake_credit);
            REG_EMPTY_START: prdata = PDATA_W'(r_cfg.empty_start);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

### rtl/core/fsts_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table scanner
// Watches the slot records streaming out of the table memory and keeps the
// lowest free slot and the runnable slot with the least runtime.
// ----------------------------------------------------------------------------
module fsts_scan
    import fsts_pkg::*;
#(
    parameter int TASK_SLOTS = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_scan_ctl             i_ctl,
    input  logic [$clog2(TASK_SLOTS)-1:0] i_idx,
    input  t_slot                 i_slot,
    output t_scan_res             o_res,
    output logic [$clog2(TASK_SLOTS)-1:0] o_free_idx,
    output logic [$clog2(TASK_SLOTS)-1:0] o_run_idx
);

    localparam int AW = $clog2(TASK_SLOTS);

    logic            r_free_found;
    logic            r_run_found;
    logic [AW-1:0]   r_free_idx;
    logic [AW-1:0]   r_run_idx;
    logic [RT_W-1:0] r_run_rt;

    logic w_take_free;
    logic w_take_run;

    assign w_take_free = i_ctl.valid && (i_slot.state == SLOT_FREE) && !r_free_found;
    // Strictly less keeps the lowest slot on ties, since slots arrive in order.
    assign w_take_run  = i_ctl.valid && (i_slot.state == SLOT_RUNNABLE) &&
                         (!r_run_found || (i_slot.runtime < r_run_rt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_free_found <= 1'b0;
            r_run_found  <= 1'b0;
        end else begin
            if (w_take_free) begin
                r_free_found <= 1'b1;
            end
            if (w_take_run) begin
                r_run_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_free) begin
            r_free_idx <= i_idx;
        end
        if (w_take_run) begin
            r_run_idx <= i_idx;
            r_run_rt  <= i_slot.runtime;
        end
    end

    assign o_res.free_found = r_free_found;
    assign o_res.run_found  = r_run_found;
    assign o_res.run_rt     = r_run_rt;
    assign o_free_idx       = r_free_idx;
    assign o_run_idx        = r_run_idx;

endmodule

### rtl/core/fsts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the command and result ports of the scheduler over time.
// ----------------------------------------------------------------------------
module fsts_checker
    import fsts_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [OP_W-1:0]   i_operation,
    input logic              o_result_valid,
    input logic [STAT_W-1:0] o_status,
    input logic [IDX_W-1:0]  o_task_slot,
    input logic [RT_W-1:0]   o_task_runtime,
    input logic [SST_W-1:0]  o_task_state
);

    // A result is only shown once the block is ready for the next transfer.
    a_result_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted transfer either keeps the block busy or answers at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted transfer neither busy nor answered");

    // Unused operation codes are answered in the next cycle with no change.
    a_spare_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_SPARE_A || i_operation == OP_SPARE_B))
        |=> (o_result_valid && o_status == STAT_NOCHANGE && o_task_slot == '0))
        else $error("unused operation not answered as no change");

    // Full table and nothing runnable report an all-zero slot record.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == STAT_FULL || o_status == STAT_EMPTY))
        |-> (o_task_slot == '0 && o_task_runtime == '0 && o_task_state == SLOT_FREE))
        else $error("failure result carries slot data");

    // A successful transfer never reports a slot in the free state unless it
    // was released from finished, which leaves the runtime at zero.
    a_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STAT_DONE && o_task_state == SLOT_FREE)
        |-> (o_task_runtime == '0))
        else $error("freed slot with nonzero runtime");

endmodule

bind fair_share_task_scheduler fsts_checker u_fsts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_task_slot    (o_task_slot),
    .o_task_runtime (o_task_runtime),
    .o_task_state   (o_task_state)
);

### tb/sv/fair_share_task_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share scheduler result checker
// Watches the APB port and the command and result channels, and keeps its own
// slot table and register copy. When a command is accepted, it works out the
// scheduler's reply. Every result transfer is compared, field by field, with
// the oldest reply still outstanding.
// ----------------------------------------------------------------------------
module fair_share_task_scheduler_checker
    import fsts_pkg::*;
#(
    parameter int TASK_SLOTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               start,
    input  logic               busy,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [IDX_W-1:0]   i_task_index,
    input  logic               i_result_valid,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [IDX_W-1:0]   i_task_slot,
    input  logic [RT_W-1:0]    i_task_runtime,
    input  logic [SST_W-1:0]   i_task_state,
    output int                 o_fail_count,
    output int                 o_replies_pending
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot;
        logic [RT_W-1:0]   runtime;
        logic [SST_W-1:0]  state;
    } sched_reply_t;

    logic [SST_W-1:0] slot_state_tbl [TASK_SLOTS];
    logic [RT_W-1:0]  slot_rt_tbl    [TASK_SLOTS];
    t_cfg             regs;
    sched_reply_t     replies_due [$];
    sched_reply_t     seen;
    sched_reply_t     due;
    int               fail_count = 0;

    // Lowest slot among the runnable ones with the least runtime, or -1.
    function automatic int least_runnable_slot();
        int best;
        int k;
        best = -1;
        for (k = 0; k < TASK_SLOTS; k++) begin
            if (slot_state_tbl[k] == SLOT_RUNNABLE &&
                (best < 0 || slot_rt_tbl[k] < slot_rt_tbl[best]))
                best = k;
        end
        return best;
    endfunction

    // Applies one command to the slot table and returns the scheduler's reply.
    function automatic sched_reply_t dispatch_op(input logic [OP_W-1:0]  op,
                                                 input logic [IDX_W-1:0] idx);
        sched_reply_t r;
        int pick;
        int k;
        r = '0;
        if (op == OP_SUBMIT) begin
            pick = -1;
            for (k = TASK_SLOTS - 1; k >= 0; k--) begin
                if (slot_state_tbl[k] == SLOT_FREE)
                    pick = k;
            end
            if (pick < 0) begin
                r.status = STAT_FULL;
            end else begin
                k = least_runnable_slot();
                slot_rt_tbl[pick]    = (k < 0) ? regs.empty_start : slot_rt_tbl[k];
                slot_state_tbl[pick] = SLOT_RUNNABLE;
                r.status  = STAT_DONE;
                r.slot    = pick[IDX_W-1:0];
                r.runtime = slot_rt_tbl[pick];
                r.state   = SLOT_RUNNABLE;
            end
        end else if (op == OP_ACQUIRE) begin
            pick = least_runnable_slot();
            if (pick < 0) begin
                r.status = STAT_EMPTY;
            end else begin
                slot_state_tbl[pick] = SLOT_RUNNING;
                r.status  = STAT_DONE;
                r.slot    = pick[IDX_W-1:0];
                r.runtime = slot_rt_tbl[pick];
                r.state   = SLOT_RUNNING;
            end
        end else if (op > OP_UNBLOCK) begin
            r.status = STAT_NOCHANGE;
        end else if (int'(idx) >= TASK_SLOTS) begin
            r.status = STAT_NOCHANGE;
            r.slot   = idx;
        end else begin
            r.status = STAT_DONE;
            case (op)
                OP_RELEASE: begin
                    if (slot_state_tbl[idx] == SLOT_FINISHED) begin
                        slot_state_tbl[idx] = SLOT_FREE;
                        slot_rt_tbl[idx]    = '0;
                    end else if (slot_state_tbl[idx] == SLOT_RUNNING) begin
                        slot_rt_tbl[idx]    = slot_rt_tbl[idx] + RT_W'(regs.run_charge);
                        slot_state_tbl[idx] = SLOT_RUNNABLE;
                    end else begin
                        r.status = STAT_NOCHANGE;
                    end
                end
                OP_FINISH: slot_state_tbl[idx] = SLOT_FINISHED;
                OP_BLOCK:  slot_state_tbl[idx] = SLOT_BLOCKED;
                default: begin
                    // Unblock: the credit is taken only when the runtime is
                    // strictly larger, so the runtime never wraps below zero.
                    if (slot_state_tbl[idx] == SLOT_BLOCKED) begin
                        slot_state_tbl[idx] = SLOT_RUNNABLE;
                        if (slot_rt_tbl[idx] > RT_W'(regs.wake_credit))
                            slot_rt_tbl[idx] = slot_rt_tbl[idx] - RT_W'(regs.wake_credit);
                    end else begin
                        r.status = STAT_NOCHANGE;
                    end
                end
            endcase
            r.slot    = idx;
            r.runtime = slot_rt_tbl[idx];
            r.state   = slot_state_tbl[idx];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                slot_state_tbl[k] = SLOT_FREE;
                slot_rt_tbl[k]    = '0;
            end
            regs.run_charge  = RST_RUN_CHARGE;
            regs.wake_credit = RST_WAKE_CREDIT;
            regs.empty_start = RST_EMPTY_START;
            replies_due.delete();
        end else begin
            // A result and the next command can share an edge; the result
            // always belongs to the older command, so it is checked first.
            if (i_result_valid) begin
                seen = {i_status, i_task_slot, i_task_runtime, i_task_state};
                if (replies_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] result with nothing outstanding: status %0d slot %0d runtime %h state %0d",
                                 $time, seen.status, seen.slot, seen.runtime, seen.state);
                    fail_count++;
                end else begin
                    due = replies_due.pop_front();
                    if (seen !== due) begin
                        if (fail_count < 10) begin
                            $display("[%0t] result mismatch (expected / actual):", $time);
                            $display("    status %0d / %0d  slot %0d / %0d  state %0d / %0d",
                                     due.status, seen.status, due.slot, seen.slot,
                                     due.state, seen.state);
                            $display("    runtime %h / %h", due.runtime, seen.runtime);
                        end
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    REG_RUN_CHARGE:  regs.run_charge  = pwdata[CHG_W-1:0];
                    REG_WAKE_CREDIT: regs.wake_credit = pwdata[CHG_W-1:0];
                    REG_EMPTY_START: regs.empty_start = pwdata[RT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                replies_due.push_back(dispatch_op(i_operation, i_task_index));
        end
        o_fail_count      <= fail_count;
        o_replies_pending <= replies_due.size();
    end

endmodule

### tb/sv/fair_share_task_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share task scheduler testbench
// Drives directed lifecycle cases, three random phases with different sender
// gaps and register settings, and a final burst of submits that fills the
// table. The checker beside the block computes and compares every result.
// ----------------------------------------------------------------------------
module fair_share_task_scheduler_tb;
    import fsts_pkg::*;

    localparam int TASK_SLOTS       = 512;
    // The slowest run is about 620 commands, each taking up to a full table scan
    // plus a gap; the limit leaves several times that run's length.
    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int RANDOM_PER_PHASE = 25;
    localparam int LOW_WINDOW       = 31;
    localparam logic [IDX_W-1:0] TOP_SLOT    = 9'd511;
    localparam logic [IDX_W-1:0] REUSED_SLOT = 9'd300;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_operation;
    logic [IDX_W-1:0]   i_task_index;
    logic               o_result_valid;
    logic [STAT_W-1:0]  o_status;
    logic [IDX_W-1:0]   o_task_slot;
    logic [RT_W-1:0]    o_task_runtime;
    logic [SST_W-1:0]   o_task_state;

    int fail_count;
    int replies_pending;
    int gap_pct   = 0;
    int cycle_cnt = 0;

    fair_share_task_scheduler #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_task_index   (i_task_index),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_task_slot    (o_task_slot),
        .o_task_runtime (o_task_runtime),
        .o_task_state   (o_task_state)
    );

    fair_share_task_scheduler_checker #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_task_index      (i_task_index),
        .i_result_valid    (o_result_valid),
        .i_status          (o_status),
        .i_task_slot       (o_task_slot),
        .i_task_runtime    (o_task_runtime),
        .i_task_state      (o_task_state),
        .o_fail_count      (fail_count),
        .o_replies_pending (replies_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** fair_share_task_scheduler: FAILED **");
            $finish;
        end
    end

    // Random filler above a 16-bit register value, which the block must ignore.
    function automatic logic [PDATA_W-1:0] pad16(input logic [CHG_W-1:0] v);
        return {32'($urandom), 16'($urandom), v};
    endfunction

    function automatic logic [RT_W-1:0] rand64();
        return {32'($urandom), 32'($urandom)};
    endfunction

    // One command transfer, preceded by a random gap with start low.
    task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_operation  = op;
        i_task_index = idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Holds off until every outstanding result has come back.
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        @(posedge i_clk);
        while (replies_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] reg_id, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_id, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Most commands target the low slots where submits land, so lifecycles
    // get exercised; the rest spread over the whole index field.
    task automatic issue_random();
        int pick;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 20)
            op = OP_SUBMIT;
        else if (pick < 38)
            op = OP_ACQUIRE;
        else if (pick < 58)
            op = OP_RELEASE;
        else if (pick < 68)
            op = OP_FINISH;
        else if (pick < 78)
            op = OP_BLOCK;
        else if (pick < 95)
            op = OP_UNBLOCK;
        else if (pick < 97)
            op = OP_SPARE_A;
        else
            op = OP_SPARE_B;
        if ($urandom_range(3) != 0)
            idx = IDX_W'($urandom_range(LOW_WINDOW));
        else
            idx = IDX_W'($urandom_range((1 << IDX_W) - 1));
        issue(op, idx);
    endtask

    task automatic random_phase(input int gap, input logic [CHG_W-1:0] charge,
                                input logic [CHG_W-1:0] credit,
                                input logic [RT_W-1:0] empty_rt);
        int n;
        settle();
        cfg_write(REG_RUN_CHARGE, pad16(charge));
        cfg_write(REG_WAKE_CREDIT, pad16(credit));
        cfg_write(REG_EMPTY_START, empty_rt);
        gap_pct = gap;
        for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2 || $urandom_range(63) == 0)
                settle();
            issue_random();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_operation  = OP_SUBMIT;
        i_task_index = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings. The first transfer waits out the table clear.
        issue(OP_ACQUIRE, '0);          // nothing runnable
        issue(OP_RELEASE, '0);          // free slot, no change
        issue(OP_UNBLOCK, '0);
        issue(OP_SPARE_A, TOP_SLOT);
        issue(OP_SPARE_B, '0);
        issue(OP_SUBMIT, TOP_SLOT);     // empty start runtime
        issue(OP_SUBMIT, '0);           // copies the least runnable runtime
        issue(OP_ACQUIRE, '0);
        issue(OP_RELEASE, '0);          // charge wraps the runtime to zero
        issue(OP_ACQUIRE, '0);
        issue(OP_BLOCK, '0);
        issue(OP_UNBLOCK, '0);          // runtime below the credit stays
        issue(OP_UNBLOCK, '0);
        issue(OP_RELEASE, 9'd1);
        issue(OP_FINISH, TOP_SLOT);
        issue(OP_RELEASE, TOP_SLOT);    // finished slot is freed
        issue(OP_BLOCK, TOP_SLOT);
        issue(OP_UNBLOCK, TOP_SLOT);
        issue(OP_FINISH, 9'd1);
        issue(OP_RELEASE, 9'd1);

        // A runtime equal to the credit must not be reduced.
        settle();
        cfg_write(REG_EMPTY_START, 64'd1000);
        issue(OP_ACQUIRE, '0);
        issue(OP_ACQUIRE, '0);
        issue(OP_SUBMIT, '0);
        issue(OP_BLOCK, 9'd1);
        issue(OP_UNBLOCK, 9'd1);
        settle();
        cfg_write(REG_WAKE_CREDIT, pad16(16'd999));
        issue(OP_BLOCK, 9'd1);
        issue(OP_UNBLOCK, 9'd1);

        random_phase(21, '0, '1, '1);
        random_phase(84, '1, '0, '0);
        random_phase(0, 16'($urandom), 16'($urandom), rand64());

        // Fill the table, then free one slot and fill it again.
        settle();
        cfg_write(REG_RUN_CHARGE, pad16(16'($urandom)));
        cfg_write(REG_WAKE_CREDIT, pad16(16'($urandom)));
        cfg_write(REG_EMPTY_START, rand64());
        gap_pct = 0;
        repeat (TASK_SLOTS + 2) issue(OP_SUBMIT, IDX_W'($urandom));
        issue(OP_FINISH, REUSED_SLOT);
        issue(OP_RELEASE, REUSED_SLOT);
        issue(OP_SUBMIT, '0);
        issue(OP_SUBMIT, '0);
        issue(OP_ACQUIRE, '0);

        settle();
        repeat (TASK_SLOTS + 4) @(posedge i_clk);
        if (fail_count == 0 && replies_pending == 0)
            $display("** fair_share_task_scheduler: PASSED **");
        else
            $display("** fair_share_task_scheduler: FAILED **");
        $finish;
    end

endmodule
